// ===== rtl/ouart_pkg.sv =====
package ouart_pkg;

	// frame shape: data bits between start and stop
	localparam int FRAME_BITS = 8;

	// field and state widths
	localparam int SAMPLE_W = 8;
	localparam int DATA_W = 8;
	localparam int RATIO_W = 12;
	localparam int CHAN_W = 3;
	localparam int COUNT_W = 4;
	localparam int OFFSET_W = 16;
	localparam int MULT_W = 5;
	localparam int PROD_W = RATIO_W + MULT_W;
	localparam int CFG_IDX_W = 1;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SAMPLES_PER_BIT = 1'b0,
		CFG_CHANNEL_SELECT = 1'b1
	} cfg_idx_t;

	// register reset values and limits
	localparam logic [RATIO_W-1:0] RATIO_RESET = 12'd80;
	localparam logic [RATIO_W-1:0] RATIO_MIN = 12'd16;
	localparam logic [CHAN_W-1:0] CHAN_RESET = 3'd0;
	localparam logic [COUNT_W-1:0] FRAME_BITS_C = COUNT_W'(FRAME_BITS);
	localparam logic [COUNT_W-1:0] MARK_SAT = COUNT_W'(FRAME_BITS + 1);

endpackage

// ===== rtl/oversampled_uart_frame_decoder.sv =====
// a sample accepted sits in the input register, and a result that it completes is loaded
// into the result register that drives the master side
// throughput: one sample per cycle, the input stalls only while a finished frame waits
// on a held master side; the path is the 12x5 multiply and the 16-bit offset compare
// reset: arst_n clears all decoder state and empties both registers; the ratio
// returns to 5.0 (80) and the channel select to bit 0
module oversampled_uart_frame_decoder (
	input  logic clk,
	input  logic arst_n,
	// sample_byte
	input  logic [ouart_pkg::SAMPLE_W-1:0] s_axis_tdata,
	input  logic s_axis_tlast,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// data_byte
	output logic [ouart_pkg::DATA_W-1:0] m_axis_tdata,
	// framing_error
	output logic m_axis_tuser,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [ouart_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ouart_pkg::RATIO_W-1:0] cfg_data
);
	import ouart_pkg::*;

	// configuration registers
	logic [RATIO_W-1:0] ratio_q;
	logic [CHAN_W-1:0] chan_q;

	// input stage
	logic valid_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic last_s1;

	// decoder state
	logic [COUNT_W-1:0] mark_run_q;
	logic in_frame_q;
	logic [OFFSET_W-1:0] offset_q;
	logic [COUNT_W-1:0] bit_index_q;
	logic [DATA_W-1:0] shift_q;

	// result register
	logic out_valid_q;
	logic [DATA_W-1:0] out_data_q;
	logic out_err_q;

	// decode signals
	logic line;
	logic [RATIO_W-1:0] ratio_eff;
	logic [MULT_W-1:0] mult;
	logic [PROD_W-1:0] prod;
	logic [OFFSET_W-1:0] point;
	logic [OFFSET_W-1:0] offset_inc;
	logic reached;
	logic produce;
	logic advance;

	logic [COUNT_W-1:0] mark_run_d;
	logic in_frame_d;
	logic [OFFSET_W-1:0] offset_d;
	logic [COUNT_W-1:0] bit_index_d;
	logic [DATA_W-1:0] shift_d;

	assign cfg_ready = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q <= RATIO_RESET;
			chan_q <= CHAN_RESET;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_SAMPLES_PER_BIT: ratio_q <= cfg_data;
				CFG_CHANNEL_SELECT: chan_q <= cfg_data[CHAN_W-1:0];
				default: ;
			endcase
		end
	end

	// sampling point of the current bit: (ratio * (2k + 3)) >> 5
	always_comb begin
		line = sample_s1[chan_q];
		ratio_eff = (ratio_q < RATIO_MIN) ? RATIO_MIN : ratio_q;
		mult = {bit_index_q, 1'b1} + MULT_W'(2);
		prod = PROD_W'(ratio_eff) * PROD_W'(mult);
		point = OFFSET_W'(prod[PROD_W-1:5]);
		offset_inc = offset_q + OFFSET_W'(1);
		reached = (offset_inc >= point);
		produce = valid_s1 && in_frame_q && (bit_index_q >= FRAME_BITS_C) && reached;
	end

	// stall the decode stage only when its result has nowhere to go
	assign advance = valid_s1 && !(produce && out_valid_q && !m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// next decoder state
	always_comb begin
		mark_run_d = mark_run_q;
		in_frame_d = in_frame_q;
		offset_d = offset_q;
		bit_index_d = bit_index_q;
		shift_d = shift_q;
		if (!in_frame_q) begin
			// hunting for an idle run and a start edge
			if (line) begin
				if (mark_run_q < MARK_SAT) begin
					mark_run_d = mark_run_q + COUNT_W'(1);
				end
			end else if (mark_run_q > FRAME_BITS_C) begin
				in_frame_d = 1'b1;
				offset_d = '0;
				bit_index_d = '0;
				shift_d = '0;
			end else begin
				mark_run_d = '0;
			end
		end else begin
			offset_d = offset_inc;
			if (bit_index_q < FRAME_BITS_C) begin
				// data bit; a bit past DATA_W would be timed but dropped
				if (reached) begin
					if (bit_index_q < COUNT_W'(DATA_W)) begin
						shift_d = shift_q | (DATA_W'(line) << bit_index_q[2:0]);
					end
					bit_index_d = bit_index_q + COUNT_W'(1);
				end
			end else if (reached) begin
				// stop bit closes the frame
				in_frame_d = 1'b0;
				offset_d = '0;
				bit_index_d = '0;
				shift_d = '0;
				mark_run_d = line ? MARK_SAT : '0;
			end
		end
		// end of capture drops any partial frame
		if (last_s1) begin
			mark_run_d = '0;
			in_frame_d = 1'b0;
			offset_d = '0;
			bit_index_d = '0;
			shift_d = '0;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			sample_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// decoder state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_run_q <= '0;
			in_frame_q <= 1'b0;
			offset_q <= '0;
			bit_index_q <= '0;
			shift_q <= '0;
		end else if (advance) begin
			mark_run_q <= mark_run_d;
			in_frame_q <= in_frame_d;
			offset_q <= offset_d;
			bit_index_q <= bit_index_d;
			shift_q <= shift_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && produce) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && produce) begin
			out_data_q <= shift_q;
			out_err_q <= !line;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;
	assign m_axis_tuser = out_err_q;

	// hunting state leaves no frame position behind
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_frame_q |-> (offset_q == '0) && (bit_index_q == '0) && (shift_q == '0))
		else $error("frame position left over while hunting");

	// bit count never passes the stop bit, mark count never passes its saturation value
	assert property (@(posedge clk) disable iff (!arst_n)
		(bit_index_q <= FRAME_BITS_C) && (mark_run_q <= MARK_SAT))
		else $error("bit index or mark run out of range");

	// a result waiting on a stalled master side is never overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_axis_tready |=> out_valid_q && $stable(out_data_q))
		else $error("pending result lost");

endmodule
